// ----- rtl/qttsg_pkg.sv -----
package qttsg_pkg;

  localparam int DEFAULT_QUEUE_DEPTH   = 16;
  localparam int DEFAULT_COUNTER_WIDTH = 32;

  localparam int CMD_W    = 2;
  localparam int DIV_W    = 8;
  localparam int LEN_W    = 8;
  localparam int AMP_W    = 14;
  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 5;
  localparam int ENTRY_W  = 2 * DIV_W + LEN_W;
  localparam int TENTHS_W = 18;
  localparam int MOD_W    = 18;
  localparam int LFSR_W   = 16;
  localparam int CFG_IDX_W = 1;

  // phase step 109375 over period 176400*n reduces by 175 to 625 over 1008*n
  localparam int PHASE_MULT   = 625;
  localparam int PHASE_MULT_W = 10;
  localparam int MOD_UNIT     = 1008;

  localparam int TENTHS_PER_UNIT   = 882;
  localparam int TENTHS_PER_SAMPLE = 10;

  localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(8192);
  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hACE1;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_ENABLE = 1'd1;

endpackage

// ----- rtl/queued_two_tone_square_generator.sv -----
// Two-voice square-wave tone generator with a note queue. A push transaction
// queues a note (two divisors and a length); a full queue drops it and flags
// dropped. A push or a clear transaction goes from idle straight to done. A
// tick transaction yields one sample: a silent tick passes pop, prep, sum and
// done; a sounding one also passes mod, where a single restoring remainder
// unit handles one bit of sample_count*625 per cycle and runs once per voice.
// in_ready is high only between transactions; one finished result is held in
// the output register and the next transaction may be accepted while it waits.
// Registers: index 0 is the voice amplitude, index 1 enables the noise added
// to sounding samples.
module queued_two_tone_square_generator #(
  parameter int QUEUE_DEPTH   = qttsg_pkg::DEFAULT_QUEUE_DEPTH,
  parameter int COUNTER_WIDTH = qttsg_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [qttsg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qttsg_pkg::AMP_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [qttsg_pkg::CMD_W-1:0]           cmd,
  input  logic [qttsg_pkg::DIV_W-1:0]           tone_a_divisor,
  input  logic [qttsg_pkg::DIV_W-1:0]           tone_b_divisor,
  input  logic [qttsg_pkg::LEN_W-1:0]           length_units,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [qttsg_pkg::SAMPLE_W-1:0] sample,
  output logic                                  note_active,
  output logic [qttsg_pkg::LEVEL_W-1:0]         queue_level,
  output logic                                  dropped
);
  import qttsg_pkg::*;

  localparam int AW   = $clog2(QUEUE_DEPTH);
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW   = COUNTER_WIDTH + PHASE_MULT_W;
  localparam int BW   = $clog2(PW);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_POP  = 6'b000010,
    S_PREP = 6'b000100,
    S_MOD  = 6'b001000,
    S_SUM  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;

  logic [ENTRY_W-1:0]       mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]       rd;
  logic [AW-1:0]            head;
  logic [AW-1:0]            tail;
  logic [CNTW-1:0]          count;
  logic [COUNTER_WIDTH-1:0] sample_count;
  logic [TENTHS_W-1:0]      remaining;
  logic [2*DIV_W-1:0]       tones;
  logic [LFSR_W-1:0]        lfsr;
  logic [AMP_W-1:0]         amplitude;
  logic                     noise_en;

  logic [PW-1:0]            prod;
  logic [MOD_W-1:0]         modulus;
  logic [MOD_W-1:0]         rem;
  logic [BW-1:0]            bit_idx;
  logic                     voice;
  logic [1:0]               signs;
  logic                     active;

  logic signed [SAMPLE_W-1:0] res_sample;
  logic                       res_active;
  logic                       res_dropped;

  logic                 accept;
  logic                 is_full;
  logic [MOD_W:0]       rem_sh;
  logic [MOD_W-1:0]     rem_next;
  logic [DIV_W-1:0]     div_a;
  logic [DIV_W-1:0]     div_b;
  logic [LFSR_W-1:0]    lfsr_next;
  logic signed [SAMPLE_W:0] amp_s;
  logic signed [SAMPLE_W:0] va;
  logic signed [SAMPLE_W:0] vb;
  logic signed [SAMPLE_W:0] sum;
  logic signed [SAMPLE_W:0] mix;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign is_full  = (count == CNTW'(QUEUE_DEPTH));
  assign div_a    = tones[2*DIV_W-1:DIV_W];
  assign div_b    = tones[DIV_W-1:0];

  // one step of the restoring remainder
  always_comb begin
    rem_sh = {rem, prod[bit_idx]};
    if (rem_sh >= {1'b0, modulus}) begin
      rem_next = MOD_W'(rem_sh - {1'b0, modulus});
    end else begin
      rem_next = rem_sh[MOD_W-1:0];
    end
  end

  always_comb begin
    lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[LFSR_W-1:1]};
    amp_s = (SAMPLE_W+1)'(amplitude);
    va = signs[0] ? amp_s : -amp_s;
    vb = signs[1] ? amp_s : -amp_s;
    sum = '0;
    if (div_a != '0) begin
      sum = sum + va;
    end
    if (div_b != '0) begin
      sum = sum + vb;
    end
    if (div_a != '0 && div_b != '0) begin
      sum = (sum > 0) ? amp_s : -amp_s;
    end
    mix = sum;
    if (noise_en) begin
      // low ten bits minus 512
      mix = sum + (SAMPLE_W+1)'(signed'({~lfsr_next[9], lfsr_next[8:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cmd == CMD_PUSH && !is_full) begin
      mem[tail] <= {tone_a_divisor, tone_b_divisor, length_units};
    end
    rd <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      tail         <= '0;
      count        <= '0;
      sample_count <= '0;
      remaining    <= '0;
      tones        <= '0;
      lfsr         <= LFSR_SEED;
      amplitude    <= AMP_RESET;
      noise_en     <= 1'b1;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AMPLITUDE:    amplitude <= cfg_data;
          REG_NOISE_ENABLE: noise_en  <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_sample  <= '0;
            res_active  <= 1'b0;
            res_dropped <= (cmd == CMD_PUSH) && is_full;
            case (cmd)
              CMD_PUSH: begin
                if (!is_full) begin
                  tail  <= (tail == AW'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
                  count <= count + 1'b1;
                end
                state <= S_DONE;
              end
              CMD_TICK: begin
                state <= S_POP;
              end
              CMD_CLEAR: begin
                head         <= '0;
                tail         <= '0;
                count        <= '0;
                sample_count <= '0;
                remaining    <= '0;
                state        <= S_DONE;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          if (remaining == '0 && count != '0) begin
            head      <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count     <= count - 1'b1;
            tones     <= rd[ENTRY_W-1:LEN_W];
            remaining <= TENTHS_W'(rd[LEN_W-1:0]) * TENTHS_W'(TENTHS_PER_UNIT);
          end
          state <= S_PREP;
        end
        S_PREP: begin
          active  <= (remaining != '0);
          prod    <= PW'(sample_count) * PW'(PHASE_MULT);
          modulus <= MOD_W'(div_a) * MOD_W'(MOD_UNIT);
          rem     <= '0;
          bit_idx <= BW'(PW - 1);
          voice   <= 1'b0;
          state   <= (remaining != '0) ? S_MOD : S_SUM;
        end
        S_MOD: begin
          if (bit_idx == '0) begin
            signs[voice] <= (rem_next < (modulus >> 1));
            rem          <= '0;
            bit_idx      <= BW'(PW - 1);
            voice        <= 1'b1;
            modulus      <= MOD_W'(div_b) * MOD_W'(MOD_UNIT);
            if (voice) begin
              state <= S_SUM;
            end
          end else begin
            rem     <= rem_next;
            bit_idx <= bit_idx - 1'b1;
          end
        end
        S_SUM: begin
          res_active <= active;
          if (active) begin
            res_sample <= SAMPLE_W'(mix);
            if (noise_en) begin
              lfsr <= lfsr_next;
            end
          end
          remaining <= (remaining > TENTHS_W'(TENTHS_PER_SAMPLE)) ?
                       remaining - TENTHS_W'(TENTHS_PER_SAMPLE) : '0;
          sample_count <= sample_count + 1'b1;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            sample      <= res_sample;
            note_active <= res_active;
            queue_level <= LEVEL_W'(count);
            dropped     <= res_dropped;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> queue_level == LEVEL_W'(QUEUE_DEPTH))
    else $error("drop flagged with room in queue");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !note_active |-> sample == '0)
    else $error("nonzero sample without a note");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MOD && modulus != '0 |-> rem < modulus)
    else $error("remainder out of range");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready right after a transaction");
`endif

endmodule

// ----- dv/queued_two_tone_square_generator_test.sv -----
`timescale 1ns / 100ps

module queued_two_tone_square_generator_test;
  import qttsg_pkg::*;

  localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 120;
  localparam int ITEMS_PER_PHASE = 350;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [CMD_W-1:0] op;
    logic [DIV_W-1:0] div_a;
    logic [DIV_W-1:0] div_b;
    logic [LEN_W-1:0] len;
  } tone_cmd_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       active;
    logic [LEVEL_W-1:0]         level;
    logic                       dropped;
  } tone_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [AMP_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           cmd = '0;
  logic [DIV_W-1:0]           tone_a_divisor = '0;
  logic [DIV_W-1:0]           tone_b_divisor = '0;
  logic [LEN_W-1:0]           length_units = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       note_active;
  logic [LEVEL_W-1:0]         queue_level;
  logic                       dropped;

  queued_two_tone_square_generator i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .tone_a_divisor (tone_a_divisor),
    .tone_b_divisor (tone_b_divisor),
    .length_units   (length_units),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .sample         (sample),
    .note_active    (note_active),
    .queue_level    (queue_level),
    .dropped        (dropped)
  );

  always #5 clk = ~clk;

  // tone generator state mirror
  logic [ENTRY_W-1:0]           note_store [DEPTH];
  int unsigned                  q_head;
  int unsigned                  q_tail;
  int unsigned                  q_level;
  logic [DEFAULT_COUNTER_WIDTH-1:0] tick_count;
  int unsigned                  tenths_left;
  logic [DIV_W-1:0]             voice_a;
  logic [DIV_W-1:0]             voice_b;
  logic [LFSR_W-1:0]            noise_reg;
  logic [AMP_W-1:0]             amp_level;
  logic                         noise_on;

  tone_cmd_t    cmd_queue [$];
  tone_result_t sample_queue [$];
  tone_cmd_t    cur_cmd;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           err_count = 0;
  int           result_count = 0;
  int           cycle_count = 0;

  function automatic int voice_polarity(logic [DEFAULT_COUNTER_WIDTH-1:0] k,
                                        logic [DIV_W-1:0] n);
    longint unsigned span;
    longint unsigned phase;
    span = 64'd176400 * n;
    phase = ((64'(k) % span) * 64'd109375) % span;
    return (phase < 64'd88200 * n) ? 1 : -1;
  endfunction

  function automatic int next_noise();
    logic fb;
    fb = noise_reg[0] ^ noise_reg[2] ^ noise_reg[3] ^ noise_reg[5];
    noise_reg = {fb, noise_reg[LFSR_W-1:1]};
    return int'(noise_reg[9:0]) - 512;
  endfunction

  function automatic tone_result_t compute_tone_result(tone_cmd_t it);
    tone_result_t res;
    logic [ENTRY_W-1:0] entry;
    int acc;
    res.active = 1'b0;
    res.dropped = 1'b0;
    acc = 0;
    case (it.op)
      CMD_PUSH: begin
        if (q_level >= DEPTH) begin
          res.dropped = 1'b1;
        end else begin
          note_store[q_tail] = {it.div_a, it.div_b, it.len};
          q_tail = (q_tail + 1) % DEPTH;
          q_level++;
        end
      end
      CMD_TICK: begin
        if (tenths_left == 0 && q_level > 0) begin
          entry = note_store[q_head];
          q_head = (q_head + 1) % DEPTH;
          q_level--;
          voice_a = entry[ENTRY_W-1 -: DIV_W];
          voice_b = entry[LEN_W +: DIV_W];
          tenths_left = int'(entry[LEN_W-1:0]) * 882;
        end
        if (tenths_left != 0) begin
          res.active = 1'b1;
          if (voice_a != 0) acc += voice_polarity(tick_count, voice_a) * int'(amp_level);
          if (voice_b != 0) acc += voice_polarity(tick_count, voice_b) * int'(amp_level);
          if (voice_a != 0 && voice_b != 0) acc = (acc > 0) ? int'(amp_level) : -int'(amp_level);
          if (noise_on) acc += next_noise();
        end
        tenths_left = (tenths_left > 10) ? tenths_left - 10 : 0;
        tick_count = tick_count + 1'b1;
      end
      CMD_CLEAR: begin
        q_head = 0;
        q_tail = 0;
        q_level = 0;
        tick_count = '0;
        tenths_left = 0;
      end
      default: ;
    endcase
    res.sample = acc[SAMPLE_W-1:0];
    res.level = q_level[LEVEL_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  task automatic check_result();
    tone_result_t want;
    result_count++;
    if (sample_queue.size() == 0) begin
      report_mismatch($sformatf("transaction %0d: result with nothing pending", result_count));
    end else begin
      want = sample_queue.pop_front();
      if (sample !== want.sample)
        report_mismatch($sformatf("transaction %0d: sample %0d, expected %0d",
                                  result_count, sample, want.sample));
      if (note_active !== want.active)
        report_mismatch($sformatf("transaction %0d: note_active %0b, expected %0b",
                                  result_count, note_active, want.active));
      if (queue_level !== want.level)
        report_mismatch($sformatf("transaction %0d: queue_level %0d, expected %0d",
                                  result_count, queue_level, want.level));
      if (dropped !== want.dropped)
        report_mismatch($sformatf("transaction %0d: dropped %0b, expected %0b",
                                  result_count, dropped, want.dropped));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) sample_queue.push_back(compute_tone_result(cur_cmd));
      if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cur_cmd = cmd_queue.pop_front();
        cmd <= cur_cmd.op;
        tone_a_divisor <= cur_cmd.div_a;
        tone_b_divisor <= cur_cmd.div_b;
        length_units <= cur_cmd.len;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic add_cmd(logic [CMD_W-1:0] op, int a, int b, int len);
    tone_cmd_t it;
    it.op = op;
    it.div_a = a[DIV_W-1:0];
    it.div_b = b[DIV_W-1:0];
    it.len = len[LEN_W-1:0];
    cmd_queue.push_back(it);
  endtask

  function automatic int rand_div();
    return ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 255);
  endfunction

  function automatic int rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 0;
    if (r < 96) return $urandom_range(1, 2);
    return $urandom_range(0, 255);
  endfunction

  task automatic add_other(logic [CMD_W-1:0] op);
    add_cmd(op, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  task automatic add_random_cmds(int n);
    int made;
    int r;
    int k;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 1) begin
        // burst that overfills the note queue
        for (k = 0; k < DEPTH + 2; k++) add_cmd(CMD_PUSH, rand_div(), rand_div(), rand_len());
        made += DEPTH + 2;
      end else if (r < 3) begin
        add_other(CMD_CLEAR);
        made++;
      end else if (r < 5) begin
        add_other(CMD_UNUSED);
        made++;
      end else if (r < 22) begin
        add_cmd(CMD_PUSH, rand_div(), rand_div(), rand_len());
        made++;
      end else begin
        add_other(CMD_TICK);
        made++;
      end
    end
  endtask

  task automatic add_directed_cmds();
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_UNUSED, 255, 255, 255);
    add_cmd(CMD_PUSH, 1, 0, 0);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_PUSH, 255, 255, 255);
    add_cmd(CMD_PUSH, 0, 0, 1);
    add_cmd(CMD_TICK, 255, 255, 255);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_UNUSED, 0, 0, 0);
    add_cmd(CMD_CLEAR, 255, 255, 255);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_PUSH, 0, 0, 1);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_CLEAR, 0, 0, 0);
    add_cmd(CMD_PUSH, 200, 0, 3);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_CLEAR, 0, 0, 0);
    add_cmd(CMD_PUSH, 0, 7, 1);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_TICK, 0, 0, 0);
    add_cmd(CMD_CLEAR, 0, 0, 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[AMP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AMPLITUDE: amp_level = value[AMP_W-1:0];
      REG_NOISE_ENABLE: noise_on = value[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || in_valid || sample_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    q_head = 0;
    q_tail = 0;
    q_level = 0;
    tick_count = '0;
    tenths_left = 0;
    voice_a = '0;
    voice_b = '0;
    noise_reg = LFSR_SEED;
    amp_level = AMP_RESET;
    noise_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 83;
    write_reg(REG_AMPLITUDE, 16383);
    write_reg(REG_NOISE_ENABLE, 1);
    add_directed_cmds();
    add_random_cmds(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 30;
    write_reg(REG_AMPLITUDE, $urandom_range(1, 16382));
    write_reg(REG_NOISE_ENABLE, 0);
    add_random_cmds(ITEMS_PER_PHASE);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_AMPLITUDE, 0);
    write_reg(REG_NOISE_ENABLE, 1);
    add_random_cmds(ITEMS_PER_PHASE);
    wait_drained();

    write_reg(REG_AMPLITUDE, $urandom_range(0, 16383));
    write_reg(REG_NOISE_ENABLE, 1);
    add_random_cmds(ITEMS_PER_PHASE);
    wait_drained();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
